// ----- design/kvls_pkg.sv -----
// Shared constants and types for the keyframe vector lerp sampler.
package kvls_pkg;

	localparam int KEY_DEPTH = 64;
	localparam int IDX_W     = $clog2(KEY_DEPTH);
	localparam int CNT_W     = 7;
	localparam int SLOT_W    = 6;
	localparam int TIME_W    = 31;
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int BF_W      = FRAC_W + 1;
	localparam int COMP_N    = 3;
	localparam int COMP_W    = $clog2(COMP_N);
	localparam int DIV_W     = $clog2(FRAC_W);

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef logic [COMP_N-1:0][VAL_W-1:0] vec_t;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SRCH = 9'b000000010,
		S_F0   = 9'b000000100,
		S_F1   = 9'b000001000,
		S_F2   = 9'b000010000,
		S_DIV  = 9'b000100000,
		S_MUL  = 9'b001000000,
		S_ACC  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

endpackage

// ----- design/kvls_if.sv -----
// Channel interfaces: request, response and configuration write.
interface kvls_req_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [5:0]  key_slot;
	logic [30:0] key_stamp;
	logic signed [31:0] value_x;
	logic signed [31:0] value_y;
	logic signed [31:0] value_z;
	logic [30:0] sample_time;

	modport source (output valid, opcode, key_slot, key_stamp, value_x, value_y, value_z,
		sample_time, input ready);
	modport sink (input valid, opcode, key_slot, key_stamp, value_x, value_y, value_z,
		sample_time, output ready);
endinterface

interface kvls_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] result_x;
	logic signed [31:0] result_y;
	logic signed [31:0] result_z;
	logic [5:0]  segment_index;
	logic [16:0] blend_factor;

	modport source (output valid, result_x, result_y, result_z, segment_index, blend_factor,
		input ready);
	modport sink (input valid, result_x, result_y, result_z, segment_index, blend_factor,
		output ready);
endinterface

interface kvls_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

// ----- design/keyframe_vector_lerp_sampler.sv -----
// Top level: keyframe track store with linear search, serial divide and lerp.
//
//  channel | dir | handshake    | carries
//  --------+-----+--------------+------------------------------------------
//  cfg     | in  | valid/ready  | key_count (7 bits), always ready
//  req     | in  | valid/ready  | opcode, key slot, key time, vector, sample time
//  rsp     | out | valid/ready  | interpolated vector, segment index, factor
//
// A load transfer writes its key in the cycle it is taken and the block is ready
// again on the next cycle. A sample runs the segment search (one key per cycle,
// up to key_count keys), fetches the two segment keys, divides for the 16-bit
// fraction if needed, blends each component, hands off. The search and the two
// key fetches share the one read port of the time memory; the divider retires
// one quotient bit per cycle and one multiplier serves the three components.
// Reset clears control state and sets key_count to 1; the key memories keep
// whatever they hold. A stalled response waits in the output register while the
// next item is taken; only a finished sample that finds it still full waits.
module keyframe_vector_lerp_sampler (
	input  logic clk,
	input  logic arst_n,
	kvls_cfg_if.sink   cfg,
	kvls_req_if.sink   req,
	kvls_rsp_if.source rsp
);
	import kvls_pkg::*;

	// key storage: one time memory, one vector memory, each with a registered read
	logic [TIME_W-1:0] tmem [KEY_DEPTH];
	vec_t              vmem [KEY_DEPTH];
	logic [TIME_W-1:0] t_rd;
	vec_t              v_rd;
	logic [IDX_W-1:0]  t_addr;
	logic [IDX_W-1:0]  v_addr;

	state_t            state_q;
	logic [CNT_W-1:0]  kc_q;
	logic [CNT_W-1:0]  n_eff;
	logic [TIME_W-1:0] ts_q;
	logic              one_q;
	logic [CNT_W-1:0]  ad_q;
	logic [CNT_W-1:0]  pa_q;
	logic              pv_q;
	logic [IDX_W-1:0]  i_q;
	logic [TIME_W-1:0] t0_q;
	vec_t              va_q;
	vec_t              vb_q;
	logic [VAL_W-1:0]  gap_q;
	logic [VAL_W-1:0]  rem_q;
	logic [FRAC_W-1:0] quo_q;
	logic [DIV_W-1:0]  dc_q;
	logic [BF_W-1:0]   f_q;
	logic [COMP_W-1:0] c_q;
	logic signed [VAL_W+BF_W:0] prod_q;
	vec_t              res_q;

	logic              out_v_q;
	vec_t              out_vec_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [BF_W-1:0]   out_bf_q;

	logic              req_go;
	logic signed [VAL_W-1:0] num;
	logic signed [VAL_W-1:0] gap;
	logic [VAL_W-1:0]  rem2;
	logic signed [VAL_W:0]   diff;
	logic signed [VAL_W+BF_W+2:0] acc;
	logic [IDX_W-1:0]  i_nx;

	assign req_go    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	// effective key count: zero reads as one, large values saturate
	always_comb begin
		if (kc_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (kc_q > CNT_W'(KEY_DEPTH)) begin
			n_eff = CNT_W'(KEY_DEPTH);
		end else begin
			n_eff = kc_q;
		end
	end

	assign i_nx = i_q + IDX_W'(1);

	// read address: search walks ad_q, then the segment start, then its end
	always_comb begin
		unique case (state_q)
			S_SRCH:  t_addr = ad_q[IDX_W-1:0];
			S_F1:    t_addr = i_nx;
			default: t_addr = i_q;
		endcase
		v_addr = (state_q == S_F1) ? i_nx : i_q;
	end

	always_ff @(posedge clk) begin
		if (req_go && req.opcode == OP_LOAD && 32'(req.key_slot) < KEY_DEPTH) begin
			tmem[req.key_slot[IDX_W-1:0]] <= req.key_stamp;
			vmem[req.key_slot[IDX_W-1:0]] <= {req.value_z, req.value_y, req.value_x};
		end
		t_rd <= tmem[t_addr];
		v_rd <= vmem[v_addr];
	end

	// time differences for the factor, taken when the segment end arrives
	assign num  = $signed({1'b0, ts_q}) - $signed({1'b0, t0_q});
	assign gap  = $signed({1'b0, t_rd}) - $signed({1'b0, t0_q});
	assign rem2 = {rem_q[VAL_W-2:0], 1'b0};

	// blend: a*(1-f) + b*f == (a << 16) + (b - a)*f, then round half up
	assign diff = $signed({vb_q[c_q][VAL_W-1], vb_q[c_q]})
		- $signed({va_q[c_q][VAL_W-1], va_q[c_q]});
	assign acc  = $signed({{4{va_q[c_q][VAL_W-1]}}, va_q[c_q], FRAC_W'(0)})
		+ (VAL_W+BF_W+3)'(prod_q)
		+ $signed((VAL_W+BF_W+3)'(1 << (FRAC_W-1)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kc_q    <= CNT_W'(1);
			out_v_q <= 1'b0;
			pv_q    <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				kc_q <= cfg.data;
			end
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_go && req.opcode == OP_SAMPLE) begin
						ts_q  <= req.sample_time;
						i_q   <= '0;
						one_q <= (n_eff == CNT_W'(1));
						ad_q  <= CNT_W'(1);
						pv_q  <= 1'b0;
						state_q <= (n_eff == CNT_W'(1)) ? S_F0 : S_SRCH;
					end
				end
				S_SRCH: begin
					// issue the next key time while checking the one just read
					ad_q <= ad_q + CNT_W'(1);
					pa_q <= ad_q;
					pv_q <= (ad_q < n_eff);
					if (pv_q) begin
						if (ts_q < t_rd) begin
							i_q     <= IDX_W'(pa_q - CNT_W'(1));
							pv_q    <= 1'b0;
							state_q <= S_F0;
						end else if (pa_q == n_eff - CNT_W'(1)) begin
							i_q     <= '0;
							pv_q    <= 1'b0;
							state_q <= S_F0;
						end
					end
				end
				S_F0: begin
					state_q <= S_F1;
				end
				S_F1: begin
					t0_q    <= t_rd;
					va_q    <= v_rd;
					state_q <= S_F2;
				end
				S_F2: begin
					// a single key blends with itself; its neighbor may never have been loaded
					vb_q  <= one_q ? va_q : v_rd;
					c_q   <= '0;
					gap_q <= gap;
					rem_q <= num;
					quo_q <= '0;
					dc_q  <= '0;
					if (one_q || gap <= 0 || num <= 0) begin
						f_q     <= '0;
						state_q <= S_MUL;
					end else if (num >= gap) begin
						f_q     <= BF_W'(1 << FRAC_W);
						state_q <= S_MUL;
					end else begin
						f_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					// restoring divide, one quotient bit per cycle
					if (rem2 >= gap_q) begin
						rem_q <= rem2 - gap_q;
						quo_q <= {quo_q[FRAC_W-2:0], 1'b1};
					end else begin
						rem_q <= rem2;
						quo_q <= {quo_q[FRAC_W-2:0], 1'b0};
					end
					dc_q <= dc_q + DIV_W'(1);
					if (dc_q == DIV_W'(FRAC_W - 1)) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (f_q == '0 && quo_q != '0) begin
						f_q <= {1'b0, quo_q};
					end
					prod_q  <= diff * $signed({1'b0, ((f_q == '0) ? {1'b0, quo_q} : f_q)});
					state_q <= S_ACC;
				end
				S_ACC: begin
					res_q[c_q] <= acc[VAL_W+FRAC_W-1:FRAC_W];
					c_q <= c_q + COMP_W'(1);
					state_q <= (c_q == COMP_W'(COMP_N - 1)) ? S_DONE : S_MUL;
				end
				S_DONE: begin
					// hand off once the output register is free
					if (!out_v_q || rsp.ready) begin
						out_v_q   <= 1'b1;
						out_vec_q <= res_q;
						out_idx_q <= i_q;
						out_bf_q  <= f_q;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid         = out_v_q;
	assign rsp.result_x      = out_vec_q[0];
	assign rsp.result_y      = out_vec_q[1];
	assign rsp.result_z      = out_vec_q[2];
	assign rsp.segment_index = SLOT_W'(out_idx_q);
	assign rsp.blend_factor  = out_bf_q;

endmodule
